>>> sv/assert_macros.svh
// Assertion helpers used by the checker file adsr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AST_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define AST_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  `AST_HOLDS(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

>>> sv/adsr_pkg.sv
package adsr_pkg;

  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned DIV_STEPS    = 17;
  localparam int unsigned ENTRY_W      = 60;

  localparam logic [15:0] FULL_SCALE = 16'hFFFF;
  localparam logic [24:0] TIMER_MAX  = 25'h1FFFFFF;

  // Register reset values
  localparam logic [23:0] ATTACK_RST  = 24'd0;
  localparam logic [23:0] DECAY_RST   = 24'd24000;
  localparam logic [15:0] SUSTAIN_RST = 16'd45875;
  localparam logic [23:0] RELEASE_RST = 24'd24000;
  localparam logic [9:0]  STEP_RST    = 10'd1;
  localparam logic [15:0] THRESH_RST  = 16'd1638;

  typedef enum logic [2:0] {
    SEG_IDLE    = 3'd0,
    SEG_ATTACK  = 3'd1,
    SEG_DECAY   = 3'd2,
    SEG_SUSTAIN = 3'd3,
    SEG_RELEASE = 3'd4
  } seg_e;

  typedef enum logic [2:0] {
    CFG_ATTACK  = 3'd0,
    CFG_DECAY   = 3'd1,
    CFG_SUSTAIN = 3'd2,
    CFG_RELEASE = 3'd3,
    CFG_STEP    = 3'd4,
    CFG_THRESH  = 3'd5
  } cfg_idx_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic mul;
    logic dinit;
    logic dstep;
    logic level;
    logic vca;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic direct;
    logic out_free;
  } stat_t;

endpackage

>>> sv/adsr_if.sv
interface adsr_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel;
  logic        channel_used;
  logic signed [15:0] gate_level;
  logic signed [15:0] vca_sample;

  modport source (output valid, channel, channel_used, gate_level, vca_sample, input ready);
  modport sink   (input valid, channel, channel_used, gate_level, vca_sample, output ready);
endinterface

interface adsr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_channel;
  logic [15:0] envelope_level;
  logic signed [15:0] vca_output;
  logic [2:0]  segment_now;

  modport source (output valid, out_channel, envelope_level, vca_output, segment_now,
                  input ready);
  modport sink   (input valid, out_channel, envelope_level, vca_output, segment_now,
                  output ready);
endinterface

>>> sv/poly_adsr_envelope_vca_unit.sv
// Polyphonic linear ADSR envelope with VCA. One transaction on item_i carries one sample of
// one voice channel and yields one transaction on result_o with the new envelope level,
// the scaled sample and the segment. Items are handled one at a time: an item on a ramp
// segment (attack, decay or release with a nonzero time) passes through the multiply and
// the bit-serial restoring divider that scales the ramp before its level is formed;
// idle, sustain, zero-time segments and channels beyond Channels skip both. A finished
// result waits in the output register while the next item is taken. Per-channel state sits
// in a single-port-read RAM with one valid bit per channel, so no clearing pass is needed.
module poly_adsr_envelope_vca_unit #(
  parameter int unsigned Channels = adsr_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  adsr_in_if.sink     item_i,
  adsr_out_if.source  result_o
);

  adsr_pkg::cmd_t  cmd;
  adsr_pkg::stat_t stat;

  adsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  adsr_dp #(.Channels(Channels)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .ch_i          (item_i.channel),
    .used_i        (item_i.channel_used),
    .gate_i        (item_i.gate_level),
    .vin_i         (item_i.vca_sample),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .out_channel_o (result_o.out_channel),
    .envelope_o    (result_o.envelope_level),
    .vca_o         (result_o.vca_output),
    .segment_o     (result_o.segment_now)
  );

endmodule

>>> sv/adsr_ram.sv
module adsr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/adsr_ctrl.sv
module adsr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  adsr_pkg::stat_t stat_i,
  output adsr_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL, ST_DINIT, ST_DIV, ST_LEVEL, ST_VCA, ST_EMIT
  } state_e;

  localparam int unsigned CntW = $clog2(adsr_pkg::DIV_STEPS);

  state_e         state_q;
  logic [CntW-1:0] cnt_q;

  // Sequencer: state and divider step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE:  if (in_valid_i) state_q <= ST_READ;
        ST_READ:  state_q <= stat_i.direct ? ST_LEVEL : ST_MUL;
        ST_MUL:   state_q <= ST_DINIT;
        ST_DINIT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(adsr_pkg::DIV_STEPS - 1)) state_q <= ST_LEVEL;
        end
        ST_LEVEL: state_q <= ST_VCA;
        ST_VCA:   state_q <= ST_EMIT;
        ST_EMIT:  if (stat_i.out_free) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = (state_q == ST_IDLE);
    cmd_o.load  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.eval  = (state_q == ST_READ);
    cmd_o.mul   = (state_q == ST_MUL);
    cmd_o.dinit = (state_q == ST_DINIT);
    cmd_o.dstep = (state_q == ST_DIV);
    cmd_o.level = (state_q == ST_LEVEL);
    cmd_o.vca   = (state_q == ST_VCA);
    cmd_o.emit  = (state_q == ST_EMIT) && stat_i.out_free;
  end

endmodule

>>> sv/adsr_dp.sv
module adsr_dp #(
  parameter int unsigned Channels = adsr_pkg::CHANNELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic [3:0]         ch_i,
  input  logic               used_i,
  input  logic signed [15:0] gate_i,
  input  logic signed [15:0] vin_i,
  input  adsr_pkg::cmd_t     cmd_i,
  output adsr_pkg::stat_t    stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         out_channel_o,
  output logic [15:0]        envelope_o,
  output logic signed [15:0] vca_o,
  output logic [2:0]         segment_o
);

  localparam int unsigned AW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned EW = adsr_pkg::ENTRY_W;

  // Configuration registers
  logic [23:0]        atk_q, dec_q, rel_q;
  logic [15:0]        sus_q;
  logic [9:0]         step_q;
  logic signed [15:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atk_q  <= adsr_pkg::ATTACK_RST;
      dec_q  <= adsr_pkg::DECAY_RST;
      sus_q  <= adsr_pkg::SUSTAIN_RST;
      rel_q  <= adsr_pkg::RELEASE_RST;
      step_q <= adsr_pkg::STEP_RST;
      thr_q  <= adsr_pkg::THRESH_RST;
    end else if (cfg_we_i) begin
      case (adsr_pkg::cfg_idx_e'(cfg_idx_i))
        adsr_pkg::CFG_ATTACK:  atk_q  <= cfg_data_i;
        adsr_pkg::CFG_DECAY:   dec_q  <= cfg_data_i;
        adsr_pkg::CFG_SUSTAIN: sus_q  <= cfg_data_i[15:0];
        adsr_pkg::CFG_RELEASE: rel_q  <= cfg_data_i;
        adsr_pkg::CFG_STEP:    step_q <= cfg_data_i[9:0];
        adsr_pkg::CFG_THRESH:  thr_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Captured transaction
  logic [3:0]         ch_q;
  logic               used_q;
  logic signed [15:0] gate_q, vin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q   <= ch_i;
      used_q <= used_i;
      gate_q <= gate_i;
      vin_q  <= vin_i;
    end
  end

  logic [AW-1:0] addr;
  logic          in_range;
  assign addr     = AW'(ch_q);
  assign in_range = (32'(ch_q) < Channels);

  // Per-channel state: {segment, timer, level, start level}
  logic [EW-1:0]       rdata, wdata;
  logic [Channels-1:0] valid_q;
  logic                ram_we;

  adsr_ram #(.Width(EW), .Depth(Channels)) u_state (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (cmd_i.load),
    .raddr_i (AW'(ch_i)),
    .rdata_o (rdata)
  );

  // Entries never written read as zero
  logic               ent_ok;
  adsr_pkg::seg_e     cur_seg;
  logic [24:0]        cur_t;
  logic [15:0]        cur_lvl, cur_st;

  always_comb begin
    ent_ok  = in_range && valid_q[addr];
    cur_seg = ent_ok ? adsr_pkg::seg_e'(rdata[59:57]) : adsr_pkg::SEG_IDLE;
    cur_t   = ent_ok ? rdata[56:32] : '0;
    cur_lvl = ent_ok ? rdata[31:16] : '0;
    cur_st  = ent_ok ? rdata[15:0]  : '0;
  end

  // Segment transition
  logic           gate_hi;
  logic [25:0]    adv;
  logic [24:0]    t_adv, step25;
  adsr_pkg::seg_e seg_n;
  logic [24:0]    t_n;
  logic [15:0]    s_n, x_d, denv_d;
  logic [23:0]    d_d;
  logic           direct_d;

  always_comb begin
    gate_hi = used_q && (gate_q > thr_q);
    step25  = 25'(step_q);
    adv     = {1'b0, cur_t} + 26'(step_q);
    t_adv   = (adv > 26'(adsr_pkg::TIMER_MAX)) ? adsr_pkg::TIMER_MAX : adv[24:0];
    seg_n   = cur_seg;
    t_n     = cur_t;
    s_n     = cur_st;
    if (gate_hi) begin
      case (cur_seg)
        adsr_pkg::SEG_IDLE: begin
          seg_n = adsr_pkg::SEG_ATTACK;
          t_n   = step25;
        end
        adsr_pkg::SEG_ATTACK: begin
          t_n = t_adv;
          if (t_adv >= 25'(atk_q)) begin
            seg_n = adsr_pkg::SEG_DECAY;
            t_n   = t_adv - 25'(atk_q);
          end
        end
        adsr_pkg::SEG_DECAY: begin
          t_n = t_adv;
          if (t_adv >= 25'(dec_q)) seg_n = adsr_pkg::SEG_SUSTAIN;
        end
        adsr_pkg::SEG_RELEASE: begin
          seg_n = adsr_pkg::SEG_ATTACK;
          t_n   = step25;
          s_n   = cur_lvl;
        end
        default: ;
      endcase
    end else begin
      case (cur_seg)
        adsr_pkg::SEG_IDLE: ;
        adsr_pkg::SEG_RELEASE: begin
          t_n = t_adv;
          if (t_adv >= 25'(rel_q)) begin
            seg_n = adsr_pkg::SEG_IDLE;
            s_n   = '0;
          end
        end
        default: begin
          seg_n = adsr_pkg::SEG_RELEASE;
          t_n   = step25;
          s_n   = cur_lvl;
        end
      endcase
    end
    if (!in_range) seg_n = adsr_pkg::SEG_IDLE;

    // Ramp operands; segments without a ramp take their level directly
    x_d      = '0;
    d_d      = '0;
    direct_d = 1'b1;
    denv_d   = '0;
    case (seg_n)
      adsr_pkg::SEG_ATTACK: begin
        x_d      = adsr_pkg::FULL_SCALE - s_n;
        d_d      = atk_q;
        direct_d = (atk_q == '0);
        denv_d   = adsr_pkg::FULL_SCALE;
      end
      adsr_pkg::SEG_DECAY: begin
        x_d      = adsr_pkg::FULL_SCALE - sus_q;
        d_d      = dec_q;
        direct_d = (dec_q == '0);
        denv_d   = sus_q;
      end
      adsr_pkg::SEG_SUSTAIN: denv_d = sus_q;
      adsr_pkg::SEG_RELEASE: begin
        x_d      = s_n;
        d_d      = rel_q;
        direct_d = (rel_q == '0);
      end
      default: ;
    endcase
  end

  // Working registers
  adsr_pkg::seg_e     seg_q;
  logic [24:0]        t_q;
  logic [15:0]        s_q, x_q, denv_q, env_q;
  logic [23:0]        d_q;
  logic               direct_q, range_q, sat_q;
  logic [40:0]        num_q;
  logic [23:0]        rem_q;
  logic [16:0]        quo_q;
  logic signed [15:0] vout_q;

  logic [24:0] trial;
  logic        ge;
  logic [16:0] part;
  logic [17:0] sum;
  logic [15:0] env_d;
  logic [16:0] vin17, mag, pq;
  logic [32:0] prod;

  always_comb begin
    // One restoring divider step
    trial = {rem_q, quo_q[16]};
    ge    = (trial >= {1'b0, d_q});
    // Quotient, clamped above full scale
    part  = sat_q ? 17'h10000 : quo_q;
    sum   = {2'b00, s_q} + {1'b0, part};
    case (seg_q)
      adsr_pkg::SEG_ATTACK:
        env_d = (sum > 18'(adsr_pkg::FULL_SCALE)) ? adsr_pkg::FULL_SCALE : sum[15:0];
      adsr_pkg::SEG_DECAY:
        env_d = (part > 17'(adsr_pkg::FULL_SCALE)) ? 16'd0 :
                16'(17'(adsr_pkg::FULL_SCALE) - part);
      adsr_pkg::SEG_RELEASE:
        env_d = (part > {1'b0, s_q}) ? 16'd0 : 16'({1'b0, s_q} - part);
      default: env_d = '0;
    endcase
    if (direct_q) env_d = denv_q;
    // VCA: sign and magnitude
    vin17 = {vin_q[15], vin_q};
    mag   = vin_q[15] ? (17'd0 - vin17) : vin17;
    prod  = 33'(mag) * 33'(env_q);
    pq    = prod[32:16];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      seg_q    <= seg_n;
      t_q      <= t_n;
      s_q      <= s_n;
      x_q      <= x_d;
      d_q      <= d_d;
      direct_q <= direct_d || !in_range;
      denv_q   <= in_range ? denv_d : 16'd0;
      range_q  <= in_range;
    end
    if (cmd_i.mul) begin
      num_q <= 41'(t_q) * 41'(x_q);
    end
    if (cmd_i.dinit) begin
      sat_q <= (num_q >= {d_q, 17'd0});
      rem_q <= num_q[40:17];
      quo_q <= num_q[16:0];
    end
    if (cmd_i.dstep) begin
      rem_q <= ge ? 24'(trial - {1'b0, d_q}) : trial[23:0];
      quo_q <= {quo_q[15:0], ge};
    end
    if (cmd_i.level) begin
      env_q <= env_d;
    end
    if (cmd_i.vca) begin
      vout_q <= vin_q[15] ? 16'(17'd0 - pq) : pq[15:0];
    end
  end

  // Write back and valid bits
  assign ram_we = cmd_i.emit && range_q;
  assign wdata  = {seg_q, t_q, env_q, s_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[addr] <= 1'b1;
    end
  end

  // Output register
  logic valid_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_out_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_out_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_out_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_channel_o <= ch_q;
      envelope_o    <= env_q;
      vca_o         <= vout_q;
      segment_o     <= seg_q;
    end
  end

  assign out_valid_o     = valid_out_q;
  assign stat_o.direct   = direct_d || !in_range;
  assign stat_o.out_free = !valid_out_q || out_ready_i;

endmodule

>>> sv/adsr_checker.sv
`include "assert_macros.svh"

module adsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_env_i,
  input logic [15:0] out_vca_i,
  input logic [2:0]  out_seg_i
);

  // Transactions accepted but not yet delivered
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 2'(in_valid_i && in_ready_i) - 2'(out_valid_i && out_ready_i);
    end
  end

  `AST_IMPLIES(a_no_orphan_out, clk_i, rst_ni, out_valid_i, cnt_q != 2'd0,
               "result without item")
  `AST_IMPLIES(a_busy_no_ready, clk_i, rst_ni, cnt_q == 2'd2, !in_ready_i,
               "third item taken")
  `AST_IMPLIES(a_idle_silent, clk_i, rst_ni,
               out_valid_i && out_seg_i == adsr_pkg::SEG_IDLE,
               out_env_i == 16'd0 && out_vca_i == 16'd0, "idle output not zero")
  `AST_HOLDS(a_out_hold, clk_i, rst_ni,
             out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_env_i),
             "stalled result changed")

endmodule

bind poly_adsr_envelope_vca_unit adsr_checker u_adsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_env_i   (result_o.envelope_level),
  .out_vca_i   (result_o.vca_output),
  .out_seg_i   (result_o.segment_now)
);

>>> verif/adsr_envelope_checker.sv
module adsr_envelope_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  adsr_in_if          item_mon,
  adsr_out_if         result_mon,
  output int          mismatch_cnt_o,
  output int          pending_cnt_o
);

  typedef struct packed {
    logic [3:0]         channel;
    logic [15:0]        envelope;
    logic signed [15:0] vca;
    adsr_pkg::seg_e     segment;
  } envelope_res_t;

  // Mirrored register file
  logic [23:0]        attack_q, decay_q, release_q;
  logic [15:0]        sustain_q;
  logic [9:0]         step_q;
  logic signed [15:0] thresh_q;

  // Mirrored per-voice state
  adsr_pkg::seg_e seg_q   [adsr_pkg::CHANNELS_DEF];
  logic [24:0]    timer_q [adsr_pkg::CHANNELS_DEF];
  logic [15:0]    level_q [adsr_pkg::CHANNELS_DEF];
  logic [15:0]    start_q [adsr_pkg::CHANNELS_DEF];

  envelope_res_t envelope_due_q[$];

  function automatic logic [24:0] timer_advance(logic [24:0] t);
    logic [25:0] n;
    n = {1'b0, t} + 26'(step_q);
    return (n > 26'(adsr_pkg::TIMER_MAX)) ? adsr_pkg::TIMER_MAX : n[24:0];
  endfunction

  // Linear ramp for the segment, clamped to the range from zero to full scale
  function automatic logic [15:0] ramp_level(adsr_pkg::seg_e seg, logic [24:0] t,
                                             logic [15:0] s);
    longint unsigned part;
    case (seg)
      adsr_pkg::SEG_ATTACK: begin
        if (attack_q == 0) return adsr_pkg::FULL_SCALE;
        part = (longint'(t) * (65535 - longint'(s))) / longint'(attack_q);
        return (s + part > 65535) ? adsr_pkg::FULL_SCALE : 16'(s + part);
      end
      adsr_pkg::SEG_DECAY: begin
        if (decay_q == 0) return sustain_q;
        part = (longint'(t) * (65535 - longint'(sustain_q))) / longint'(decay_q);
        return (part > 65535) ? 16'd0 : 16'(65535 - part);
      end
      adsr_pkg::SEG_SUSTAIN: return sustain_q;
      adsr_pkg::SEG_RELEASE: begin
        if (release_q == 0) return 16'd0;
        part = (longint'(t) * longint'(s)) / longint'(release_q);
        return (part > s) ? 16'd0 : 16'(s - part);
      end
      default: return 16'd0;
    endcase
  endfunction

  // Advance one voice by one sample and build the expected result
  function automatic envelope_res_t next_envelope(logic [3:0] ch, logic used,
                                                  logic signed [15:0] gate,
                                                  logic signed [15:0] vin);
    envelope_res_t  r;
    adsr_pkg::seg_e seg;
    logic [24:0]    t;
    logic [15:0]    env;
    longint         mag, prod;
    seg = seg_q[ch];
    t   = timer_q[ch];
    if (used && gate > thresh_q) begin
      case (seg)
        adsr_pkg::SEG_IDLE: begin
          seg = adsr_pkg::SEG_ATTACK;
          t   = 25'(step_q);
        end
        adsr_pkg::SEG_ATTACK: begin
          t = timer_advance(t);
          if (t >= attack_q) begin
            seg = adsr_pkg::SEG_DECAY;
            t   = t - attack_q;
          end
        end
        adsr_pkg::SEG_DECAY: begin
          t = timer_advance(t);
          if (t >= decay_q) seg = adsr_pkg::SEG_SUSTAIN;
        end
        adsr_pkg::SEG_RELEASE: begin
          seg         = adsr_pkg::SEG_ATTACK;
          t           = 25'(step_q);
          start_q[ch] = level_q[ch];
        end
        default: ;
      endcase
    end else if (seg == adsr_pkg::SEG_RELEASE) begin
      t = timer_advance(t);
      if (t >= release_q) begin
        seg         = adsr_pkg::SEG_IDLE;
        start_q[ch] = '0;
      end
    end else if (seg != adsr_pkg::SEG_IDLE) begin
      seg         = adsr_pkg::SEG_RELEASE;
      t           = 25'(step_q);
      start_q[ch] = level_q[ch];
    end
    env         = ramp_level(seg, t, start_q[ch]);
    seg_q[ch]   = seg;
    timer_q[ch] = t;
    level_q[ch] = env;
    // VCA: magnitude scaled, truncated toward zero
    mag  = (vin < 0) ? -longint'(vin) : longint'(vin);
    prod = (mag * env) >>> 16;
    r.channel  = ch;
    r.envelope = env;
    r.vca      = 16'((vin < 0) ? -prod : prod);
    r.segment  = seg;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    envelope_res_t exp_r;
    if (!rst_ni) begin
      attack_q  <= adsr_pkg::ATTACK_RST;
      decay_q   <= adsr_pkg::DECAY_RST;
      sustain_q <= adsr_pkg::SUSTAIN_RST;
      release_q <= adsr_pkg::RELEASE_RST;
      step_q    <= adsr_pkg::STEP_RST;
      thresh_q  <= adsr_pkg::THRESH_RST;
      for (int i = 0; i < adsr_pkg::CHANNELS_DEF; i++) begin
        seg_q[i]   = adsr_pkg::SEG_IDLE;
        timer_q[i] = '0;
        level_q[i] = '0;
        start_q[i] = '0;
      end
      envelope_due_q.delete();
      mismatch_cnt_o = 0;
      pending_cnt_o  = 0;
    end else begin
      // Result transaction: compare with the oldest expectation
      if (result_mon.valid && result_mon.ready) begin
        if (envelope_due_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          mismatch_cnt_o++;
        end else begin
          exp_r = envelope_due_q.pop_front();
          if (result_mon.out_channel !== exp_r.channel) begin
            $error("out_channel: expected %0d, actual %0d", exp_r.channel,
                   result_mon.out_channel);
            mismatch_cnt_o++;
          end
          if (result_mon.envelope_level !== exp_r.envelope) begin
            $error("envelope_level: expected %0d, actual %0d", exp_r.envelope,
                   result_mon.envelope_level);
            mismatch_cnt_o++;
          end
          if (result_mon.vca_output !== exp_r.vca) begin
            $error("vca_output: expected %0d, actual %0d", exp_r.vca,
                   result_mon.vca_output);
            mismatch_cnt_o++;
          end
          if (result_mon.segment_now !== exp_r.segment) begin
            $error("segment_now: expected %0d, actual %0d", exp_r.segment,
                   result_mon.segment_now);
            mismatch_cnt_o++;
          end
        end
      end
      // Item transaction: predict
      if (item_mon.valid && item_mon.ready) begin
        envelope_due_q.push_back(next_envelope(item_mon.channel, item_mon.channel_used,
                                               item_mon.gate_level, item_mon.vca_sample));
      end
      pending_cnt_o = envelope_due_q.size();
      // Register writes; unknown indexes are ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          adsr_pkg::CFG_ATTACK:  attack_q  <= cfg_data_i;
          adsr_pkg::CFG_DECAY:   decay_q   <= cfg_data_i;
          adsr_pkg::CFG_SUSTAIN: sustain_q <= cfg_data_i[15:0];
          adsr_pkg::CFG_RELEASE: release_q <= cfg_data_i;
          adsr_pkg::CFG_STEP:    step_q    <= cfg_data_i[9:0];
          adsr_pkg::CFG_THRESH:  thresh_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> verif/poly_adsr_envelope_vca_unit_tb.sv
module poly_adsr_envelope_vca_unit_tb;

  localparam logic [2:0] CFG_NONE  = 3'd7;
  localparam int         DRAIN_CYC = 40;
  localparam int         HOLD_CYC  = 90;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [23:0] cfg_data;
  int          mismatch_cnt;
  int          pending_cnt;
  bit          quiet;
  bit          hold_req;
  bit          gate_on [adsr_pkg::CHANNELS_DEF];
  int          thresh_now;

  adsr_in_if  item_ch ();
  adsr_out_if result_ch ();

  poly_adsr_envelope_vca_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .item_i     (item_ch),
    .result_o   (result_ch)
  );

  adsr_envelope_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .item_mon       (item_ch),
    .result_mon     (result_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run limit
  initial begin
    #5000000;
    $display("FAIL poly_adsr_envelope_vca_unit");
    $finish;
  end

  // Result side: random stall bursts, one long hold on request
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        result_ch.ready <= 1'b1;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // One register write per edge; caller lowers the enable after the batch
  task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [23:0] atk, logic [23:0] dcy, logic [15:0] sus,
                                logic [23:0] rel, logic [9:0] stp, logic [15:0] th);
    cfg_write(adsr_pkg::CFG_ATTACK, atk);
    cfg_write(adsr_pkg::CFG_DECAY, dcy);
    cfg_write(adsr_pkg::CFG_SUSTAIN, {8'h0, sus});
    cfg_write(adsr_pkg::CFG_RELEASE, rel);
    cfg_write(adsr_pkg::CFG_STEP, {14'h0, stp});
    cfg_write(adsr_pkg::CFG_THRESH, {8'hA5, th});
    cfg_write(CFG_NONE, 24'hFFFFFF);
    cfg_we <= 1'b0;
    thresh_now = $signed(th);
  endtask

  function automatic logic [23:0] pick_time();
    case ($urandom_range(0, 7))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom_range(1, 4000));
    endcase
  endfunction

  // Drive one item and wait for its transaction
  task automatic send_item(logic [3:0] ch, logic used, logic [15:0] gate, logic [15:0] vin);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    item_ch.valid        <= 1'b1;
    item_ch.channel      <= ch;
    item_ch.channel_used <= used;
    item_ch.gate_level   <= gate;
    item_ch.vca_sample   <= vin;
    do @(posedge clk_i); while (!(item_ch.valid && item_ch.ready));
  endtask

  // Mostly well-formed gate sequences per voice, some noise
  task automatic send_random_item();
    logic [3:0] ch;
    logic       used;
    int         lvl;
    ch = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    if ($urandom_range(0, 5) == 0) gate_on[ch] = !gate_on[ch];
    used = ($urandom_range(0, 19) != 0);
    if ($urandom_range(0, 9) == 0) lvl = $signed(16'($urandom));
    else if (gate_on[ch] && thresh_now < 32767)
      lvl = thresh_now + 1 + $urandom_range(0, 32766 - thresh_now);
    else lvl = -32768 + $urandom_range(0, thresh_now + 32768);
    send_item(ch, used, 16'(lvl), 16'($urandom));
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  initial begin
    logic [9:0]  stp;
    logic [15:0] sus, th;
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = adsr_pkg::CFG_ATTACK;
    cfg_data             = '0;
    item_ch.valid        = 1'b0;
    item_ch.channel      = '0;
    item_ch.channel_used = 1'b0;
    item_ch.gate_level   = '0;
    item_ch.vca_sample   = '0;
    quiet                = 1'b0;
    hold_req             = 1'b0;
    thresh_now           = $signed(adsr_pkg::THRESH_RST);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings (zero attack time), field extremes, gate edges
    send_item(4'd0, 1'b1, 16'h7FFF, 16'h7FFF);
    send_item(4'd0, 1'b1, 16'h7FFF, 16'h8000);
    send_item(4'd0, 1'b1, 16'h8000, 16'hFFFF);
    send_item(4'd0, 1'b1, 16'd1638, 16'h7FFF);
    send_item(4'd0, 1'b0, 16'h7FFF, 16'h8000);
    send_item(4'd0, 1'b1, 16'd1639, 16'h1234);
    send_item(4'd15, 1'b1, 16'h7FFF, 16'h0000);
    send_item(4'd15, 1'b0, 16'h7FFF, 16'hFFFF);
    send_item(4'd15, 1'b0, 16'h7FFF, 16'h8000);
    send_item(4'd5, 1'b1, 16'h8000, 16'h7FFF);
    drain();

    // Zero durations everywhere, then a zero timer step
    apply_settings(24'd0, 24'd0, 16'hFFFF, 24'd0, 10'd1, 16'h8000);
    send_item(4'd1, 1'b1, 16'h0000, 16'h7FFF);
    send_item(4'd1, 1'b1, 16'h0001, 16'h8000);
    send_item(4'd1, 1'b1, 16'h8000, 16'h4000);
    send_item(4'd1, 1'b1, 16'h8000, 16'hC000);
    drain();
    apply_settings(24'd3, 24'd2, 16'd0, 24'd2, 10'd0, 16'h0000);
    send_item(4'd2, 1'b1, 16'h7FFF, 16'h7FFF);
    send_item(4'd2, 1'b1, 16'h7FFF, 16'h8001);
    send_item(4'd2, 1'b1, 16'h8000, 16'h7FFF);
    send_item(4'd2, 1'b1, 16'h8000, 16'h7FFF);
    drain();

    // Long durations, largest step; highest threshold (gate never high), then lowest threshold
    apply_settings(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 10'h3FF, 16'h7FFF);
    send_item(4'd3, 1'b1, 16'h7FFF, 16'h7FFF);
    send_item(4'd3, 1'b1, 16'h7FFF, 16'h8000);
    drain();
    apply_settings(24'hFFFFFF, 24'hFFFFFF, 16'h8000, 24'hFFFFFF, 10'h3FF, 16'h8000);
    repeat (8) send_item(4'd4, 1'b1, 16'h7FFF, 16'($urandom));
    send_item(4'd4, 1'b1, 16'h8000, 16'h7FFF);
    drain();

    // Random phases, each under fresh settings
    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 3))
        0:       stp = 10'd1;
        1:       stp = 10'h3FF;
        default: stp = 10'($urandom_range(1, 1023));
      endcase
      case ($urandom_range(0, 3))
        0:       sus = 16'd0;
        1:       sus = 16'hFFFF;
        default: sus = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       th = 16'($urandom);
        default: th = 16'($urandom_range(0, 4000) - 2000);
      endcase
      apply_settings(pick_time(), pick_time(), sus, pick_time(), stp, th);
      quiet = (ph == 8);
      for (int n = 0; n < 52; n++) begin
        if (ph == 3 && n == 10) hold_req = 1'b1;
        send_random_item();
      end
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("PASS poly_adsr_envelope_vca_unit");
    end else begin
      $display("FAIL poly_adsr_envelope_vca_unit");
    end
    $finish;
  end

endmodule
